// ===== src/mctm_pkg.sv =====
// ----------------------------------------------------------------------------
// mctm_pkg
// Shared constants, types and helpers of the MIDI clock tempo estimator.
// ----------------------------------------------------------------------------
package mctm_pkg;

  // Window geometry.
  localparam int WINDOW_PULSES = 96;
  localparam int MIN_PULSES    = 4;
  localparam int IDX_W         = $clog2(WINDOW_PULSES);
  localparam int CNT_W         = $clog2(WINDOW_PULSES + 1);

  // Field widths.
  localparam int TIME_W = 32;
  localparam int IVL_W  = 20;
  localparam int TMO_W  = 27;
  localparam int BPM_W  = 22;
  localparam int CFG_W  = 27;
  localparam int REG_W  = 2;

  // Tempo arithmetic: bpm_milli = 60 * 1000 * 1e6 / (24 * gap_us).
  localparam logic [TIME_W-1:0] TEMPO_NUMERATOR = 32'd2500000000;
  localparam logic [BPM_W-1:0]  TEMPO_LIMIT     = 22'd2500000;

  // Register reset values.
  localparam logic [IVL_W-1:0] MIN_INT_RST = 20'd8000;
  localparam logic [IVL_W-1:0] MAX_INT_RST = 20'd100000;
  localparam logic [IVL_W-1:0] MIN_GAP_RST = 20'd1000;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 27'd2000000;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_RESET = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  // Register indexes.
  typedef enum logic [REG_W-1:0] {
    REG_MIN_INT = 2'd0,
    REG_MAX_INT = 2'd1,
    REG_MIN_GAP = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  // Top level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELECT,
    ST_DIVIDE
  } state_t;

  // Median selector phases.
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_COUNT,
    SEL_BITS
  } sel_phase_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] first_slot;
    logic [CNT_W-1:0] gap_cnt;
    logic [IVL_W-1:0] min_gap;
  } sel_ctl_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [TIME_W-1:0] median;
  } sel_stat_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [BPM_W-1:0] quot;
  } div_stat_t;

  // Circular slot addition; both operands are below WINDOW_PULSES.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(WINDOW_PULSES)) begin
      s = s - (IDX_W+1)'(WINDOW_PULSES);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== src/mctm_ifs.sv =====
// ----------------------------------------------------------------------------
// mctm_ifs
// Valid/ready channel interfaces: input items, results and register writes.
// ----------------------------------------------------------------------------
interface mctm_in_if import mctm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, output cmd, output time_us, input ready);
  modport sink (input valid, input cmd, input time_us, output ready);
endinterface

interface mctm_out_if import mctm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BPM_W-1:0] bpm_milli;
  logic             present;
  logic [6:0]       pulses_held;
  logic             accepted;

  modport source (output valid, output bpm_milli, output present,
                  output pulses_held, output accepted, input ready);
  modport sink (input valid, input bpm_milli, input present,
                input pulses_held, input accepted, output ready);
endinterface

interface mctm_cfg_if import mctm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/midi_clock_tempo_median_top.sv =====
// ----------------------------------------------------------------------------
// midi_clock_tempo_median_top
// MIDI clock tempo estimator: keeps the gaps of up to 96 stored pulses in a
// circular RAM and turns their upper median into thousandths of a BPM.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Contents
//   in_ch    in   cmd, time_us
//   out_ch   out  bpm_milli, present, pulses_held, accepted
//   cfg_ch   in   index, data (register writes, always ready)
//
// A poll, a reset and any rejected or stored pulse that needs no new estimate
// have their result registered at the accepting edge. A pulse that needs a new
// estimate runs the median selector, 33 passes over the held gaps at one RAM
// read per cycle, and then the divider. The input is ready only when the
// sequencer is idle and the result register is empty or being taken. Reset is
// synchronous; the gap RAM needs no clear.
//
module midi_clock_tempo_median_top import mctm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mctm_in_if.sink    in_ch,
  mctm_out_if.source out_ch,
  mctm_cfg_if.sink   cfg_ch
);

  state_t            state_r, state_nxt;
  logic [IVL_W-1:0]  min_int_r, min_int_nxt;
  logic [IVL_W-1:0]  max_int_r, max_int_nxt;
  logic [IVL_W-1:0]  min_gap_r, min_gap_nxt;
  logic [TMO_W-1:0]  timeout_r, timeout_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [TIME_W-1:0] newest_r, newest_nxt;
  logic [BPM_W-1:0]  bpm_r, bpm_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BPM_W-1:0]  out_bpm_r, out_bpm_nxt;
  logic              out_pres_r, out_pres_nxt;
  logic [6:0]        out_held_r, out_held_nxt;
  logic              out_acc_r, out_acc_nxt;

  logic              in_ready;
  logic              acc;
  logic              recompute;
  logic              is_store;
  logic              full;
  logic [TIME_W-1:0] iv;
  logic [TIME_W-1:0] gap;
  logic [IDX_W-1:0]  wr_slot;
  logic              wr_en;
  logic              pres;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] rd_data;
  sel_ctl_t          sel_ctl;
  sel_stat_t         sel_stat;
  div_ctl_t          div_ctl;
  div_stat_t         div_stat;

  // Gap storage, one entry per stored pulse slot.
  mctm_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW_PULSES)) u_gaps (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (gap),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mctm_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sel_ctl),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .stat    (sel_stat)
  );

  mctm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .stat  (div_stat)
  );

  // Handshake outputs and unit starts.
  always_comb begin
    in_ready        = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
    acc             = in_ch.valid && in_ready;
    div_ctl.start   = (state_r == ST_SELECT) && sel_stat.done && sel_stat.found;
    div_ctl.divisor = sel_stat.median;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && recompute) state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        if (sel_stat.done) state_nxt = sel_stat.found ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Window bookkeeping, configuration and result register.
  always_comb begin
    min_int_nxt   = min_int_r;
    max_int_nxt   = max_int_r;
    min_gap_nxt   = min_gap_r;
    timeout_nxt   = timeout_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    have_prev_nxt = have_prev_r;
    prev_time_nxt = prev_time_r;
    newest_nxt    = newest_r;
    bpm_nxt       = bpm_r;
    out_valid_nxt = out_valid_r;
    out_bpm_nxt   = out_bpm_r;
    out_pres_nxt  = out_pres_r;
    out_held_nxt  = out_held_r;
    out_acc_nxt   = out_acc_r;
    wr_en         = 1'b0;
    recompute     = 1'b0;

    iv       = in_ch.time_us - prev_time_r;
    gap      = in_ch.time_us - newest_r;
    full     = (count_r == CNT_W'(WINDOW_PULSES));
    wr_slot  = full ? head_r : slot_add(head_r, count_r[IDX_W-1:0]);
    is_store = (in_ch.cmd == CMD_PULSE) &&
               (!have_prev_r || ((iv > {{(TIME_W-IVL_W){1'b0}}, min_int_r}) &&
                                 (iv < {{(TIME_W-IVL_W){1'b0}}, max_int_r})));

    // Register writes.
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIN_INT: min_int_nxt = cfg_ch.data[IVL_W-1:0];
        REG_MAX_INT: max_int_nxt = cfg_ch.data[IVL_W-1:0];
        REG_MIN_GAP: min_gap_nxt = cfg_ch.data[IVL_W-1:0];
        REG_TIMEOUT: timeout_nxt = cfg_ch.data[TMO_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    // Item transaction.
    if (acc) begin
      case (in_ch.cmd)
        CMD_PULSE: begin
          have_prev_nxt = 1'b1;
          prev_time_nxt = in_ch.time_us;
          if (is_store) begin
            wr_en      = 1'b1;
            newest_nxt = in_ch.time_us;
            if (full) begin
              head_nxt = slot_add(head_r, IDX_W'(1));
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        CMD_RESET: begin
          count_nxt     = '0;
          head_nxt      = '0;
          bpm_nxt       = '0;
          have_prev_nxt = 1'b0;
        end
        default: ;
      endcase
      recompute = is_store && have_prev_r && (count_nxt >= CNT_W'(MIN_PULSES));
    end

    pres = (count_nxt != '0) &&
           ((in_ch.time_us - newest_nxt) < {{(TIME_W-TMO_W){1'b0}}, timeout_r});

    if (acc) begin
      out_pres_nxt = pres;
      out_held_nxt = count_nxt[6:0];
      out_acc_nxt  = is_store;
      out_bpm_nxt  = bpm_nxt;
      if (!recompute) out_valid_nxt = 1'b1;
    end

    // Estimate finished, or no gap qualified.
    if ((state_r == ST_SELECT) && sel_stat.done && !sel_stat.found) begin
      out_valid_nxt = 1'b1;
    end
    if ((state_r == ST_DIVIDE) && div_stat.done) begin
      bpm_nxt       = div_stat.quot;
      out_bpm_nxt   = div_stat.quot;
      out_valid_nxt = 1'b1;
    end

    sel_ctl.start      = acc && recompute;
    sel_ctl.first_slot = slot_add(head_nxt, IDX_W'(1));
    sel_ctl.gap_cnt    = count_nxt - CNT_W'(1);
    sel_ctl.min_gap    = min_gap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_int_r   <= MIN_INT_RST;
      max_int_r   <= MAX_INT_RST;
      min_gap_r   <= MIN_GAP_RST;
      timeout_r   <= TIMEOUT_RST;
      head_r      <= '0;
      count_r     <= '0;
      have_prev_r <= 1'b0;
      prev_time_r <= '0;
      newest_r    <= '0;
      bpm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_int_r   <= min_int_nxt;
      max_int_r   <= max_int_nxt;
      min_gap_r   <= min_gap_nxt;
      timeout_r   <= timeout_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      have_prev_r <= have_prev_nxt;
      prev_time_r <= prev_time_nxt;
      newest_r    <= newest_nxt;
      bpm_r       <= bpm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bpm_r  <= out_bpm_nxt;
    out_pres_r <= out_pres_nxt;
    out_held_r <= out_held_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.bpm_milli   = out_bpm_r;
  assign out_ch.present     = out_pres_r;
  assign out_ch.pulses_held = out_held_r;
  assign out_ch.accepted    = out_acc_r;

`ifndef SYNTHESIS
  // The window never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_PULSES))
    else $error("window count above depth");

  // A found median always hands over to the divider.
  a_sel_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SELECT && sel_stat.done && sel_stat.found) |=> state_r == ST_DIVIDE)
    else $error("median found but divider not started");

  // A stored pulse leaves a nonempty window in its result.
  a_acc_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_acc_r) |-> out_held_r != '0)
    else $error("stored pulse reported with empty window");

  // The estimate stays within the saturation limit.
  a_bpm_limit: assert property (@(posedge clk) disable iff (!rst_n)
    bpm_r <= TEMPO_LIMIT)
    else $error("tempo estimate above limit");
`endif

endmodule

// ===== src/mctm_ram.sv =====
// ----------------------------------------------------------------------------
// mctm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mctm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/mctm_select.sv =====
// ----------------------------------------------------------------------------
// mctm_select
// Upper median of the stored gaps by radix selection: one counting pass,
// then one pass per bit from the MSB, all over the gap RAM.
// ----------------------------------------------------------------------------
module mctm_select import mctm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sel_ctl_t          ctl,
  input  logic [TIME_W-1:0] rd_data,
  output logic [IDX_W-1:0]  rd_addr,
  output sel_stat_t         stat
);

  sel_phase_t        phase_r, phase_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]  gap_cnt_r, gap_cnt_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              dv_r, dv_nxt;
  logic              last_r, last_nxt;
  logic [IVL_W-1:0]  min_gap_r, min_gap_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [TIME_W-1:0] prefix_r, prefix_nxt;
  logic [TIME_W-1:0] mask_r, mask_nxt;
  logic [TIME_W-1:0] bit_r, bit_nxt;
  logic              done_r, done_nxt;
  logic              found_r, found_nxt;

  logic              gap_ok;
  logic              hit;
  logic [CNT_W-1:0]  cnt_sum;
  logic              pass_end;

  // Gap qualification and the match for the current pass.
  always_comb begin
    gap_ok = (rd_data > {{(TIME_W-IVL_W){1'b0}}, min_gap_r}) && (rd_data != '0);
    if (phase_r == SEL_COUNT) begin
      hit = dv_r && gap_ok;
    end else begin
      hit = dv_r && gap_ok && (((rd_data ^ prefix_r) & mask_r) == '0)
            && ((rd_data & bit_r) == '0);
    end
    cnt_sum  = cnt_r + CNT_W'(hit);
    pass_end = dv_r && last_r;
  end

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      SEL_IDLE: begin
        if (ctl.start) phase_nxt = SEL_COUNT;
      end
      SEL_COUNT: begin
        if (pass_end) phase_nxt = (cnt_sum == '0) ? SEL_IDLE : SEL_BITS;
      end
      SEL_BITS: begin
        if (pass_end && bit_r[0]) phase_nxt = SEL_IDLE;
      end
      default: phase_nxt = SEL_IDLE;
    endcase
  end

  // Address issue, counting and prefix building.
  always_comb begin
    ptr_nxt     = ptr_r;
    first_nxt   = first_r;
    gap_cnt_nxt = gap_cnt_r;
    left_nxt    = left_r;
    dv_nxt      = 1'b0;
    last_nxt    = 1'b0;
    min_gap_nxt = min_gap_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    prefix_nxt  = prefix_r;
    mask_nxt    = mask_r;
    bit_nxt     = bit_r;
    done_nxt    = 1'b0;
    found_nxt   = found_r;

    if (phase_r == SEL_IDLE) begin
      if (ctl.start) begin
        ptr_nxt     = ctl.first_slot;
        first_nxt   = ctl.first_slot;
        gap_cnt_nxt = ctl.gap_cnt;
        left_nxt    = ctl.gap_cnt;
        min_gap_nxt = ctl.min_gap;
        cnt_nxt     = '0;
      end
    end else begin
      // One RAM read per cycle while the pass has entries left.
      if (left_r != '0) begin
        ptr_nxt  = slot_add(ptr_r, IDX_W'(1));
        left_nxt = left_r - CNT_W'(1);
        dv_nxt   = 1'b1;
        last_nxt = (left_r == CNT_W'(1));
      end
      cnt_nxt = cnt_sum;
      if (pass_end) begin
        ptr_nxt  = first_r;
        left_nxt = gap_cnt_r;
        cnt_nxt  = '0;
        if (phase_r == SEL_COUNT) begin
          k_nxt      = cnt_sum >> 1;
          prefix_nxt = '0;
          mask_nxt   = '0;
          bit_nxt    = {1'b1, {(TIME_W-1){1'b0}}};
          if (cnt_sum == '0) begin
            done_nxt  = 1'b1;
            found_nxt = 1'b0;
          end
        end else begin
          if (k_r >= cnt_sum) begin
            prefix_nxt = prefix_r | bit_r;
            k_nxt      = k_r - cnt_sum;
          end
          mask_nxt = {1'b1, mask_r[TIME_W-1:1]};
          bit_nxt  = bit_r >> 1;
          if (bit_r[0]) begin
            done_nxt  = 1'b1;
            found_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SEL_IDLE;
      left_r  <= '0;
      dv_r    <= 1'b0;
      last_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      dv_r    <= dv_nxt;
      last_r  <= last_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    first_r   <= first_nxt;
    gap_cnt_r <= gap_cnt_nxt;
    min_gap_r <= min_gap_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    prefix_r  <= prefix_nxt;
    mask_r    <= mask_nxt;
    bit_r     <= bit_nxt;
  end

  assign rd_addr     = ptr_r;
  assign stat.done   = done_r;
  assign stat.found  = found_r;
  assign stat.median = prefix_r;

endmodule

// ===== src/mctm_div.sv =====
// ----------------------------------------------------------------------------
// mctm_div
// Restoring divider, one quotient bit per cycle: tempo numerator / median
// gap, saturated to the tempo limit.
// ----------------------------------------------------------------------------
module mctm_div import mctm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_ctl_t  ctl,
  output div_stat_t stat
);

  localparam int STEP_W = $clog2(TIME_W);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] num_r, num_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [TIME_W-1:0] dvs_r, dvs_nxt;
  logic              done_r, done_nxt;
  logic [BPM_W-1:0]  res_r, res_nxt;

  logic [TIME_W:0]   trial;
  logic              take;

  // One shift-and-subtract step.
  always_comb begin
    trial    = {rem_r, num_r[TIME_W-1]};
    take     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (!busy_r) begin
      if (ctl.start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
        rem_nxt  = '0;
        num_nxt  = TEMPO_NUMERATOR;
        dvs_nxt  = ctl.divisor;
      end
    end else begin
      rem_nxt  = take ? TIME_W'(trial - {1'b0, dvs_r}) : trial[TIME_W-1:0];
      num_nxt  = {num_r[TIME_W-2:0], 1'b0};
      quo_nxt  = {quo_r[TIME_W-2:0], take};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = (quo_nxt > {{(TIME_W-BPM_W){1'b0}}, TEMPO_LIMIT}) ?
                   TEMPO_LIMIT : quo_nxt[BPM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    res_r  <= res_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = res_r;

endmodule
